>>> rtl/esfr_pkg.sv
`timescale 1ns / 1ps

package esfr_pkg;

	// Payload buffer geometry
	localparam int BUF_DEPTH = 32;
	localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

	// Line codes
	localparam logic [7:0] SYNC_CODE  = 8'h7E;
	localparam logic [7:0] ESC_CODE   = 8'h7D;
	localparam logic [7:0] ESC_SYNC   = 8'h5E;
	localparam logic [7:0] ESC_ESC    = 8'h5D;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] PROTO_CODE = 8'h44;
	localparam logic [7:0] ACK_CODE   = 8'h43;

	// Frame byte positions (1-based, saturating at POS_BODY)
	localparam logic [3:0] POS_PROTO = 4'd1;
	localparam logic [3:0] POS_SEQ   = 4'd2;
	localparam logic [3:0] POS_LEN   = 4'd8;
	localparam logic [3:0] POS_GROUP = 4'd9;
	localparam logic [3:0] POS_TYPE  = 4'd10;
	localparam logic [3:0] POS_BODY  = 4'd11;

	// Footer progress
	localparam logic [1:0] FOOT_NONE = 2'd0;
	localparam logic [1:0] FOOT_LOW  = 2'd1;
	localparam logic [1:0] FOOT_DONE = 2'd2;

	// Payload length loaded at sync (-1, nine bits)
	localparam logic [8:0] REM_SYNC = 9'h1FF;

	// Destination codes
	localparam logic DEST_ACK  = 1'b0;
	localparam logic DEST_LINE = 1'b1;

	// One CRC-16-CCITT byte step, zero-init variant (byte-swap form)
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] x;
		x = {crc[7:0], crc[15:8]} ^ {8'h00, b};
		x = x ^ {12'h000, x[7:4]};
		x = x ^ {x[3:0], 12'h000};
		x = x ^ {3'b000, x[7:0], 5'b00000};
		return x;
	endfunction

	// CRC after the ack code byte; the sequence byte is folded in later
	localparam logic [15:0] ACK_CRC_SEED  = crc_step(16'h0000, ACK_CODE);
	localparam logic [15:0] ACK_CRC_RESET = crc_step(ACK_CRC_SEED, 8'h00);

	typedef enum logic [2:0] {
		E_IDLE,
		E_PASS,
		E_ACK,
		E_RD,
		E_WR
	} emit_state_t;

	typedef enum logic [2:0] {
		AF_OPEN,
		AF_CODE,
		AF_SEQ,
		AF_CRC_LO,
		AF_CRC_HI,
		AF_CLOSE
	} ack_field_t;

	// Work handed from the parser to the emitter
	typedef struct packed {
		logic              pass;
		logic              ack;
		logic [7:0]        data;
		logic [7:0]        seq;
		logic [15:0]       crc;
		logic [CNT_W-1:0]  cnt;
	} esfr_cmd_t;

endpackage

>>> rtl/esfr_ram.sv
`timescale 1ns / 1ps

module esfr_ram
	import esfr_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/esfr_parse.sv
`timescale 1ns / 1ps

module esfr_parse
	import esfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              framing_enable,
	input  logic              cfg_wr_en,
	output esfr_cmd_t         cmd,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [7:0]        wr_data
);

	logic [3:0]       pos_q, pos_d;
	logic             err_q, err_d;
	logic             esc_q, esc_d;
	logic [8:0]       rem_q, rem_d;
	logic [15:0]      crc_q, crc_d;
	logic [15:0]      fcrc_q, fcrc_d;
	logic [1:0]       fpos_q, fpos_d;
	logic             ackp_q, ackp_d;
	logic [7:0]       seq_q, seq_d;
	logic [15:0]      ackcrc_q, ackcrc_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic [7:0]  c;
	logic [3:0]  pos_n;
	logic [15:0] crc_n;
	logic        crc_now;
	logic [15:0] footer;

	always_comb begin
		pos_d    = pos_q;
		err_d    = err_q;
		esc_d    = esc_q;
		rem_d    = rem_q;
		crc_d    = crc_q;
		fcrc_d   = fcrc_q;
		fpos_d   = fpos_q;
		ackp_d   = ackp_q;
		seq_d    = seq_q;
		ackcrc_d = ackcrc_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		wr_en    = 1'b0;
		wr_addr  = cnt_q[ADDR_W-1:0];

		// unescape
		c = in_byte;
		if (esc_q) begin
			if (in_byte == ESC_ESC) begin
				c = ESC_CODE;
			end else if (in_byte == ESC_SYNC) begin
				c = SYNC_CODE;
			end
		end
		wr_data = c;

		pos_n   = (pos_q < POS_BODY) ? pos_q + 4'd1 : pos_q;
		crc_now = (rem_q != 9'd0) || (pos_n == POS_GROUP) || (pos_n == POS_TYPE);
		crc_n   = crc_now ? crc_step(crc_q, c) : crc_q;
		footer  = {c, fcrc_q[7:0]};

		if (accept) begin
			if (!framing_enable) begin
				cmd.pass = 1'b1;
				cmd.data = in_byte;
			end else if (in_byte == SYNC_CODE) begin
				if (ackp_q) begin
					cmd.ack = 1'b1;
					cmd.seq = seq_q;
					cmd.crc = ackcrc_q;
					cmd.cnt = cnt_q;
					ackp_d  = 1'b0;
				end
				cnt_d  = '0;
				err_d  = 1'b0;
				pos_d  = '0;
				esc_d  = 1'b0;
				rem_d  = REM_SYNC;
				crc_d  = '0;
				fpos_d = FOOT_NONE;
				fcrc_d = '0;
			end else if (err_q) begin
				// drop until next sync
			end else if (in_byte == ESC_CODE) begin
				esc_d = 1'b1;
			end else begin
				esc_d = 1'b0;
				pos_d = pos_n;
				crc_d = crc_n;
				if (pos_n == POS_PROTO) begin
					if (c != PROTO_CODE) begin
						err_d = 1'b1;
					end
				end else if (pos_n == POS_SEQ) begin
					seq_d    = c;
					ackcrc_d = crc_step(ACK_CRC_SEED, c);
				end else if (pos_n == POS_LEN) begin
					rem_d = {1'b0, c};
				end else if (pos_n < POS_BODY) begin
					// header bytes with no field of interest
				end else if (rem_q != 9'd0 && !rem_q[8]) begin
					rem_d = rem_q - 9'd1;
					if (cnt_q < CNT_W'(BUF_DEPTH)) begin
						wr_en = 1'b1;
						cnt_d = cnt_q + CNT_W'(1);
					end else begin
						err_d = 1'b1;
					end
				end else if (fpos_q == FOOT_NONE) begin
					fcrc_d = {8'h00, c};
					fpos_d = FOOT_LOW;
				end else if (fpos_q == FOOT_LOW) begin
					fcrc_d = footer;
					ackp_d = (footer == crc_n);
					fpos_d = FOOT_DONE;
				end
			end
		end

		// a mode change empties the buffer
		if (cfg_wr_en) begin
			cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			err_q    <= 1'b0;
			esc_q    <= 1'b0;
			rem_q    <= '0;
			crc_q    <= '0;
			fcrc_q   <= '0;
			fpos_q   <= FOOT_NONE;
			ackp_q   <= 1'b0;
			seq_q    <= '0;
			ackcrc_q <= ACK_CRC_RESET;
			cnt_q    <= '0;
		end else begin
			pos_q    <= pos_d;
			err_q    <= err_d;
			esc_q    <= esc_d;
			rem_q    <= rem_d;
			crc_q    <= crc_d;
			fcrc_q   <= fcrc_d;
			fpos_q   <= fpos_d;
			ackp_q   <= ackp_d;
			seq_q    <= seq_d;
			ackcrc_q <= ackcrc_d;
			cnt_q    <= cnt_d;
		end
	end

endmodule

>>> rtl/esfr_emit.sv
`timescale 1ns / 1ps

module esfr_emit
	import esfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  esfr_cmd_t         cmd,
	output logic              idle,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [7:0]        rd_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_dest,
	output logic              out_last
);

	emit_state_t      state_q, state_d;
	ack_field_t       fld_q, fld_d;
	logic             sub_q, sub_d;
	logic [CNT_W-1:0] ridx_q, ridx_d;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       seq_q;
	logic [15:0]      crc_q;
	logic [7:0]       pass_q;

	logic             ovalid_q;
	logic [7:0]       obyte_q;
	logic             odest_q;
	logic             olast_q;

	logic       slot_free;
	logic [7:0] raw;
	logic       stuff;
	logic       load;
	logic [7:0] load_byte;
	logic       load_dest;
	logic       load_last;
	logic       rd_last;

	assign slot_free = !ovalid_q || out_ready;
	assign rd_last   = (ridx_q + CNT_W'(1)) == cnt_q;
	assign rd_addr   = ridx_q[ADDR_W-1:0];

	always_comb begin
		case (fld_q)
			AF_OPEN:   raw = SYNC_CODE;
			AF_CODE:   raw = ACK_CODE;
			AF_SEQ:    raw = seq_q;
			AF_CRC_LO: raw = crc_q[7:0];
			AF_CRC_HI: raw = crc_q[15:8];
			AF_CLOSE:  raw = SYNC_CODE;
			default:   raw = SYNC_CODE;
		endcase
	end

	// inner fields need byte stuffing
	assign stuff = (fld_q != AF_OPEN) && (fld_q != AF_CLOSE)
		&& ((raw == SYNC_CODE) || (raw == ESC_CODE));

	// next state
	always_comb begin
		state_d = state_q;
		fld_d   = fld_q;
		sub_d   = sub_q;
		ridx_d  = ridx_q;
		case (state_q)
			E_IDLE: begin
				if (cmd.pass) begin
					state_d = E_PASS;
				end else if (cmd.ack) begin
					state_d = E_ACK;
					fld_d   = AF_OPEN;
					sub_d   = 1'b0;
				end
			end
			E_PASS: begin
				if (slot_free) begin
					state_d = E_IDLE;
				end
			end
			E_ACK: begin
				if (slot_free) begin
					if (stuff && !sub_q) begin
						sub_d = 1'b1;
					end else if (fld_q == AF_CLOSE) begin
						ridx_d  = '0;
						state_d = (cnt_q == '0) ? E_IDLE : E_RD;
					end else begin
						sub_d = 1'b0;
						fld_d = ack_field_t'(fld_q + 3'd1);
					end
				end
			end
			E_RD: begin
				state_d = E_WR;
			end
			E_WR: begin
				if (slot_free) begin
					ridx_d  = ridx_q + CNT_W'(1);
					state_d = rd_last ? E_IDLE : E_RD;
				end
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		idle      = 1'b0;
		rd_en     = 1'b0;
		load      = 1'b0;
		load_byte = raw;
		load_dest = DEST_ACK;
		load_last = 1'b0;
		case (state_q)
			E_IDLE: begin
				idle = 1'b1;
			end
			E_PASS: begin
				load      = slot_free;
				load_byte = pass_q;
				load_dest = DEST_LINE;
				load_last = 1'b1;
			end
			E_ACK: begin
				load = slot_free;
				if (stuff && !sub_q) begin
					load_byte = ESC_CODE;
				end else if (sub_q) begin
					load_byte = raw ^ ESC_XOR;
				end else begin
					load_byte = raw;
				end
				load_last = (fld_q == AF_CLOSE) && (cnt_q == '0);
			end
			E_RD: begin
				rd_en = 1'b1;
			end
			E_WR: begin
				load      = slot_free;
				load_byte = rd_data;
				load_dest = DEST_LINE;
				load_last = rd_last;
			end
			default: begin
				idle = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			fld_q    <= AF_OPEN;
			sub_q    <= 1'b0;
			ridx_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fld_q   <= fld_d;
			sub_q   <= sub_d;
			ridx_q  <= ridx_d;
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && (cmd.pass || cmd.ack)) begin
			pass_q <= cmd.data;
			seq_q  <= cmd.seq;
			crc_q  <= cmd.crc;
			cnt_q  <= cmd.cnt;
		end
		if (load) begin
			obyte_q <= load_byte;
			odest_q <= load_dest;
			olast_q <= load_last;
		end
	end

	assign out_valid = ovalid_q;
	assign out_byte  = obyte_q;
	assign out_dest  = odest_q;
	assign out_last  = olast_q;

endmodule

>>> rtl/escaped_serial_frame_receiver_ack_top.sv
`timescale 1ns / 1ps

// Escaped serial frame receiver with acknowledge. Feed received UART bytes
// on s_axis. With framing_enable at 0 every byte comes back on m_axis with
// tuser=1 (line input) and tlast=1. With framing_enable at 1 the block
// deframes HDLC-style traffic: 0x7E delimits frames, 0x7D escapes the next
// byte, byte 1 must be 0x44, byte 2 is the sequence number, byte 8 the
// payload length, bytes 9-10 group and type, then payload and a
// little-endian CRC-16-CCITT (zero init) footer. Payload bytes are held in a
// 32-entry buffer. When the footer checks, the next 0x7E emits an escaped
// ack frame (0x7E 0x43 seq crc_lo crc_hi 0x7E, tuser=0) followed by the
// buffered payload (tuser=1); tlast flags the final byte of that burst.
// Timing: a non-sync byte is absorbed in the cycle it is taken; a pass-through
// byte moves into the emitter's pass register, then into the output register.
// An ack burst puts out one byte per cycle for the ack frame while m_axis_tready
// stays high, then reads each payload byte from the buffer's single registered
// read port before loading it. New input is refused (s_axis_tready low) while
// a burst is being generated and while a pass-through byte waits to move into
// the output register, so a new byte is not taken before the previous one has
// moved; that wait stretches while the previous result still waits there.
// The buffer needs no clearing pass after reset. Write framing_enable only
// while idle; each write also empties the payload buffer.

module escaped_serial_frame_receiver_ack_top
	import esfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration: framing_enable
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	// received bytes
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	// acks and delivered payload
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] destination
	output logic       m_axis_tlast    // [0] last
);

	logic              framing_enable_q;
	logic              s_accept;
	logic              emit_idle;
	esfr_cmd_t         cmd;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framing_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			framing_enable_q <= cfg_wr_data;
		end
	end

	// a request is taken whenever the emitter state machine is idle
	assign s_axis_tready = emit_idle;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// per-byte frame decoding, CRC, buffer writes
	esfr_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (s_accept),
		.in_byte        (s_axis_tdata),
		.framing_enable (framing_enable_q),
		.cfg_wr_en      (cfg_wr_en),
		.cmd            (cmd),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data)
	);

	// payload buffer; reads and writes never overlap since input stalls
	// during a burst
	esfr_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// ack framing, payload release, output register
	esfr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idle      (emit_idle),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_dest  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

>>> rtl/esfr_chk.sv
`timescale 1ns / 1ps

module esfr_chk
	import esfr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_wr_en,
	input logic       cfg_wr_data,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);

	logic en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			en_q <= cfg_wr_data;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
		&& $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// pass-through mode: every result is a single line byte
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !en_q |-> m_axis_tuser && m_axis_tlast)
		else $error("pass-through result not a single line byte");

	// a burst ending on an ack byte ends on the closing flag
	a_ack_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && m_axis_tlast |-> m_axis_tdata == SYNC_CODE)
		else $error("ack frame not closed by sync");

	// no new request while a burst is still being produced
	a_burst_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken mid-burst");

endmodule

bind escaped_serial_frame_receiver_ack_top esfr_chk u_esfr_chk (.*);
